FILE: hdl/frp_pkg.sv
package frp_pkg;

    typedef enum logic [3:0] {
        PH_START        = 4'd0,
        PH_LABEL_FIRST  = 4'd1,
        PH_LABEL        = 4'd2,
        PH_META         = 4'd3,
        PH_AFTER_HEADER = 4'd4,
        PH_COMMENT      = 4'd5,
        PH_SEQ_LINE     = 4'd6,
        PH_SEQ_START    = 4'd7,
        PH_HALTED       = 4'd8
    } t_phase;

    localparam logic [2:0] KIND_LABEL = 3'd0;
    localparam logic [2:0] KIND_META  = 3'd1;
    localparam logic [2:0] KIND_SITE  = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [2:0] ERR_NO_START     = 3'd0;
    localparam logic [2:0] ERR_EMPTY_LABEL  = 3'd1;
    localparam logic [2:0] ERR_BAD_HEADER   = 3'd2;
    localparam logic [2:0] ERR_BAD_SYMBOL   = 3'd3;
    localparam logic [2:0] ERR_EMPTY_LINE   = 3'd4;
    localparam logic [2:0] ERR_NO_NEWLINE   = 3'd5;
    localparam logic [2:0] ERR_NO_SEQUENCE  = 3'd6;

    localparam logic [2:0] CFG_UPPER_CASE = 3'd0;
    localparam logic [2:0] CFG_VALIDATE   = 3'd1;
    localparam logic [2:0] CFG_VSYM_0     = 3'd2;
    localparam logic [2:0] CFG_VSYM_1     = 3'd3;
    localparam logic [2:0] CFG_VSYM_2     = 3'd4;
    localparam logic [2:0] CFG_VSYM_3     = 3'd5;

    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_stream;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [2:0]  error_code;
        logic [31:0] line_number;
        logic [31:0] column_number;
    } t_out_res;

    function automatic logic is_graphic(input logic [7:0] b);
        return (b >= 8'h21) && (b <= 8'h7E);
    endfunction

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= 8'h20) && (b <= 8'h7E);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b, input logic upper);
        if (upper && (b >= 8'h61) && (b <= 8'h7A)) begin
            return b - 8'h20;
        end
        return b;
    endfunction

endpackage

FILE: hdl/fasta_record_parser_core.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in_req  (t_in_req)
// out     | output    | o_out_valid / i_out_ready  | o_out_res (t_out_res)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One byte per cycle: each request is decoded against the phase register and
// the line/column counters in the cycle it is accepted; its result (if any)
// lands in the output register on the same edge.
// A new request is taken whenever the output register is empty or being drained.
// Reset (synchronous, active low) returns to record start, counters to one,
// upper-casing on, validation off and all symbols valid.
// Config writes are always taken and apply from the next cycle.
module fasta_record_parser_core
    import frp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_res    o_out_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_phase           r_phase, n_phase;
    logic [31:0]      r_line, n_line;
    logic [31:0]      r_col, n_col;
    logic             r_upper;
    logic             r_validate;
    logic [3:0][63:0] r_vsym;
    logic             r_out_valid;
    t_out_res         r_out_res;

    logic       w_fire;
    logic       w_eos;
    logic [7:0] w_b;
    logic [7:0] w_site;
    logic       w_site_bad;
    logic       w_emit;
    t_out_res   w_res;

    assign w_fire     = i_in_valid && o_in_ready;
    assign w_eos      = i_in_req.end_of_stream;
    assign w_b        = i_in_req.symbol;
    assign w_site     = fold_case(w_b, r_upper);
    assign w_site_bad = r_validate && !r_vsym[w_site[7:6]][w_site[5:0]];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;
    assign o_cfg_ready = 1'b1;

    // next phase and counters
    always_comb begin
        n_phase = r_phase;
        if (w_eos) begin
            n_phase = PH_START;
        end else begin
            case (r_phase)
                PH_START: begin
                    n_phase = (w_b == CH_GT) ? PH_LABEL_FIRST : PH_HALTED;
                end
                PH_LABEL_FIRST: begin
                    n_phase = is_graphic(w_b) ? PH_LABEL : PH_HALTED;
                end
                PH_LABEL: begin
                    if (is_graphic(w_b)) begin
                        n_phase = PH_LABEL;
                    end else if (w_b == CH_SPACE) begin
                        n_phase = PH_META;
                    end else if (w_b == CH_NEWLINE) begin
                        n_phase = PH_AFTER_HEADER;
                    end else begin
                        n_phase = PH_HALTED;
                    end
                end
                PH_META: begin
                    if (is_printable(w_b)) begin
                        n_phase = PH_META;
                    end else if (w_b == CH_NEWLINE) begin
                        n_phase = PH_AFTER_HEADER;
                    end else begin
                        n_phase = PH_HALTED;
                    end
                end
                PH_AFTER_HEADER: begin
                    if (w_b == CH_SEMI) begin
                        n_phase = PH_COMMENT;
                    end else if (w_b == CH_GT || w_b == CH_NEWLINE || w_site_bad) begin
                        n_phase = PH_HALTED;
                    end else begin
                        n_phase = PH_SEQ_LINE;
                    end
                end
                PH_COMMENT: begin
                    if (w_b == CH_NEWLINE) begin
                        n_phase = PH_AFTER_HEADER;
                    end
                end
                PH_SEQ_LINE: begin
                    if (w_b == CH_NEWLINE) begin
                        n_phase = PH_SEQ_START;
                    end else begin
                        n_phase = w_site_bad ? PH_HALTED : PH_SEQ_LINE;
                    end
                end
                PH_SEQ_START: begin
                    if (w_b == CH_GT) begin
                        n_phase = PH_LABEL_FIRST;
                    end else if (w_b == CH_NEWLINE || w_site_bad) begin
                        n_phase = PH_HALTED;
                    end else begin
                        n_phase = PH_SEQ_LINE;
                    end
                end
                default: begin
                    n_phase = PH_HALTED;
                end
            endcase
        end

        n_line = r_line;
        n_col  = r_col;
        if (w_eos) begin
            n_line = 32'd1;
            n_col  = 32'd1;
        end else if (n_phase != PH_HALTED) begin
            // every byte that does not halt advances the position
            if (w_b == CH_NEWLINE) begin
                n_line = (r_line == POS_MAX) ? r_line : r_line + 32'd1;
                n_col  = 32'd1;
            end else begin
                n_col = (r_col == POS_MAX) ? r_col : r_col + 32'd1;
            end
        end
    end

    // result of the current request
    always_comb begin
        logic       err;
        logic [2:0] code;
        logic       emit_byte;
        logic [2:0] kind;
        logic [7:0] val;

        err       = 1'b0;
        code      = ERR_NO_START;
        emit_byte = 1'b0;
        kind      = KIND_LABEL;
        val       = w_b;
        w_emit    = 1'b0;
        w_res     = '0;

        if (w_eos) begin
            case (r_phase)
                PH_SEQ_START: begin
                    emit_byte = 1'b1;
                    kind      = KIND_END;
                    val       = 8'd0;
                end
                PH_SEQ_LINE: begin
                    err  = 1'b1;
                    code = ERR_NO_NEWLINE;
                end
                PH_LABEL_FIRST: begin
                    err  = 1'b1;
                    code = ERR_EMPTY_LABEL;
                end
                PH_LABEL, PH_META, PH_AFTER_HEADER, PH_COMMENT: begin
                    err  = 1'b1;
                    code = ERR_NO_SEQUENCE;
                end
                default: begin
                    err = 1'b0;
                end
            endcase
        end else begin
            case (r_phase)
                PH_START: begin
                    err  = (w_b != CH_GT);
                    code = ERR_NO_START;
                end
                PH_LABEL_FIRST: begin
                    err       = !is_graphic(w_b);
                    code      = ERR_EMPTY_LABEL;
                    emit_byte = is_graphic(w_b);
                    kind      = KIND_LABEL;
                end
                PH_LABEL: begin
                    emit_byte = is_graphic(w_b);
                    kind      = KIND_LABEL;
                    err       = !is_graphic(w_b) && (w_b != CH_SPACE) && (w_b != CH_NEWLINE);
                    code      = ERR_BAD_HEADER;
                end
                PH_META: begin
                    emit_byte = is_printable(w_b);
                    kind      = KIND_META;
                    err       = !is_printable(w_b) && (w_b != CH_NEWLINE);
                    code      = ERR_BAD_HEADER;
                end
                PH_AFTER_HEADER: begin
                    if (w_b == CH_GT) begin
                        err  = 1'b1;
                        code = ERR_NO_SEQUENCE;
                    end else if (w_b == CH_NEWLINE) begin
                        err  = 1'b1;
                        code = ERR_EMPTY_LINE;
                    end else if (w_b != CH_SEMI) begin
                        err       = w_site_bad;
                        code      = ERR_BAD_SYMBOL;
                        emit_byte = !w_site_bad;
                        kind      = KIND_SITE;
                        val       = w_site;
                    end
                end
                PH_SEQ_LINE: begin
                    if (w_b != CH_NEWLINE) begin
                        err       = w_site_bad;
                        code      = ERR_BAD_SYMBOL;
                        emit_byte = !w_site_bad;
                        kind      = KIND_SITE;
                        val       = w_site;
                    end
                end
                PH_SEQ_START: begin
                    if (w_b == CH_GT) begin
                        emit_byte = 1'b1;
                        kind      = KIND_END;
                        val       = 8'd0;
                    end else if (w_b == CH_NEWLINE) begin
                        err  = 1'b1;
                        code = ERR_EMPTY_LINE;
                    end else begin
                        err       = w_site_bad;
                        code      = ERR_BAD_SYMBOL;
                        emit_byte = !w_site_bad;
                        kind      = KIND_SITE;
                        val       = w_site;
                    end
                end
                default: begin
                    err = 1'b0;
                end
            endcase
        end

        if (err) begin
            w_emit              = 1'b1;
            w_res.kind          = KIND_ERROR;
            w_res.error_code    = code;
            w_res.line_number   = r_line;
            w_res.column_number = r_col;
        end else if (emit_byte) begin
            w_emit      = 1'b1;
            w_res.kind  = kind;
            w_res.value = val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_line      <= 32'd1;
            r_col       <= 32'd1;
            r_out_valid <= 1'b0;
            r_upper     <= 1'b1;
            r_validate  <= 1'b0;
            r_vsym      <= '1;
        end else begin
            if (w_fire) begin
                r_phase     <= n_phase;
                r_line      <= n_line;
                r_col       <= n_col;
                r_out_valid <= w_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_UPPER_CASE: r_upper    <= i_cfg_data[0];
                    CFG_VALIDATE:   r_validate <= i_cfg_data[0];
                    CFG_VSYM_0:     r_vsym[0]  <= i_cfg_data;
                    CFG_VSYM_1:     r_vsym[1]  <= i_cfg_data;
                    CFG_VSYM_2:     r_vsym[2]  <= i_cfg_data;
                    CFG_VSYM_3:     r_vsym[3]  <= i_cfg_data;
                    default:        r_upper    <= r_upper;
                endcase
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_res <= w_res;
        end
    end

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line != 32'd0) && (r_col != 32'd0))
        else $error("line or column counter reached zero");

    a_eos_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_eos) |=> (r_phase == PH_START && r_line == 32'd1 && r_col == 32'd1))
        else $error("end marker did not rearm the parser");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_emit && w_res.kind == KIND_ERROR)
        |=> (r_phase == PH_HALTED || r_phase == PH_START))
        else $error("parser kept going after an error");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_phase == PH_HALTED) |=> !r_out_valid)
        else $error("result produced while halted");

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import frp_pkg::*;

    localparam int          EOS_MARK    = 256;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_req     in_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_res    out_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_UPPER_CASE;
    logic [63:0] cfg_data = '0;

    // Expected parser behavior: register copies and parse position
    logic         upper_sites = 1'b1;
    logic         check_sites = 1'b0;
    logic [255:0] symbol_set = '1;
    t_phase       rec_phase = PH_START;
    logic [31:0]  line_pos = 32'd1;
    logic [31:0]  col_pos = 32'd1;

    t_in_req     byte_stream[$];
    t_out_res    pending_results[$];
    int unsigned stim_count = 0;
    int unsigned cycle_count = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    fasta_record_parser_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the parse by one request; returns 1 when it yields a result.
    function automatic bit parse_expected(input t_in_req req, output t_out_res res);
        logic [7:0] b;
        logic [7:0] s;
        logic [2:0] code;
        bit         fault;
        bit         emit;
        bit         take_site;
        bit         was_halted;
        b = req.symbol;
        s = (upper_sites && b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
        res = '0;
        fault = 1'b0;
        emit = 1'b0;
        take_site = 1'b0;
        code = ERR_NO_START;
        was_halted = (rec_phase == PH_HALTED);
        if (req.end_of_stream) begin
            case (rec_phase)
                PH_SEQ_START: begin
                    res.kind = KIND_END;
                    emit = 1'b1;
                end
                PH_SEQ_LINE: begin
                    fault = 1'b1;
                    code = ERR_NO_NEWLINE;
                end
                PH_LABEL_FIRST: begin
                    fault = 1'b1;
                    code = ERR_EMPTY_LABEL;
                end
                PH_LABEL, PH_META, PH_AFTER_HEADER, PH_COMMENT: begin
                    fault = 1'b1;
                    code = ERR_NO_SEQUENCE;
                end
                default: ;
            endcase
        end else begin
            case (rec_phase)
                PH_START: begin
                    if (b == CH_GT) rec_phase = PH_LABEL_FIRST;
                    else begin
                        fault = 1'b1;
                        code = ERR_NO_START;
                    end
                end
                PH_LABEL_FIRST: begin
                    if (b < 8'h21 || b > 8'h7E) begin
                        fault = 1'b1;
                        code = ERR_EMPTY_LABEL;
                    end else begin
                        res.kind = KIND_LABEL;
                        res.value = b;
                        emit = 1'b1;
                        rec_phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    if (b >= 8'h21 && b <= 8'h7E) begin
                        res.kind = KIND_LABEL;
                        res.value = b;
                        emit = 1'b1;
                    end else if (b == CH_SPACE) begin
                        rec_phase = PH_META;
                    end else if (b == CH_NEWLINE) begin
                        rec_phase = PH_AFTER_HEADER;
                    end else begin
                        fault = 1'b1;
                        code = ERR_BAD_HEADER;
                    end
                end
                PH_META: begin
                    if (b >= 8'h20 && b <= 8'h7E) begin
                        res.kind = KIND_META;
                        res.value = b;
                        emit = 1'b1;
                    end else if (b == CH_NEWLINE) begin
                        rec_phase = PH_AFTER_HEADER;
                    end else begin
                        fault = 1'b1;
                        code = ERR_BAD_HEADER;
                    end
                end
                PH_AFTER_HEADER: begin
                    if (b == CH_SEMI) rec_phase = PH_COMMENT;
                    else if (b == CH_GT) begin
                        fault = 1'b1;
                        code = ERR_NO_SEQUENCE;
                    end else if (b == CH_NEWLINE) begin
                        fault = 1'b1;
                        code = ERR_EMPTY_LINE;
                    end else take_site = 1'b1;
                end
                PH_COMMENT: begin
                    if (b == CH_NEWLINE) rec_phase = PH_AFTER_HEADER;
                end
                PH_SEQ_LINE: begin
                    if (b == CH_NEWLINE) rec_phase = PH_SEQ_START;
                    else take_site = 1'b1;
                end
                PH_SEQ_START: begin
                    if (b == CH_GT) begin
                        res.kind = KIND_END;
                        emit = 1'b1;
                        rec_phase = PH_LABEL_FIRST;
                    end else if (b == CH_NEWLINE) begin
                        fault = 1'b1;
                        code = ERR_EMPTY_LINE;
                    end else take_site = 1'b1;
                end
                default: ;
            endcase
        end
        if (take_site) begin
            if (check_sites && !symbol_set[s]) begin
                fault = 1'b1;
                code = ERR_BAD_SYMBOL;
            end else begin
                res.kind = KIND_SITE;
                res.value = s;
                emit = 1'b1;
                rec_phase = PH_SEQ_LINE;
            end
        end
        if (fault) begin
            res = '0;
            res.kind = KIND_ERROR;
            res.error_code = code;
            res.line_number = line_pos;
            res.column_number = col_pos;
            emit = 1'b1;
            rec_phase = PH_HALTED;
        end else if (!req.end_of_stream && !was_halted) begin
            if (b == CH_NEWLINE) begin
                if (line_pos != POS_MAX) line_pos++;
                col_pos = 32'd1;
            end else if (col_pos != POS_MAX) begin
                col_pos++;
            end
        end
        // End of stream readies a new document, also after an error
        if (req.end_of_stream) begin
            rec_phase = PH_START;
            line_pos = 32'd1;
            col_pos = 32'd1;
        end
        return emit;
    endfunction

    always @(posedge clk) begin : drive_bytes
        t_in_req  nxt_req;
        t_out_res res;
        bit       nxt_valid;
        nxt_valid = in_valid;
        nxt_req = in_req;
        if (in_valid && in_ready) begin
            if (parse_expected(in_req, res))
                pending_results.insert(pending_results.size(), res);
            nxt_valid = 1'b0;
        end
        if (rst_n && !nxt_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (byte_stream.size() != 0) begin
                nxt_req = byte_stream.pop_front();
                nxt_valid = 1'b1;
                tx_gap = pick_gap(cycle_count[8:7] == 2'd0);
            end
        end
        in_valid <= nxt_valid;
        in_req <= nxt_req;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : observe_results
        t_out_res want;
        bit       nxt_ready;
        if (out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with none pending: kind %0d value %0h",
                       out_res.kind, out_res.value);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_res.kind));
                check_field("value", 32'(want.value), 32'(out_res.value));
                check_field("error_code", 32'(want.error_code), 32'(out_res.error_code));
                check_field("line_number", want.line_number, out_res.line_number);
                check_field("column_number", want.column_number, out_res.column_number);
            end
        end
        // Hold off once for a long stretch while requests keep coming
        if (!rst_n) begin
            nxt_ready = 1'b0;
        end else if (!hold_done && results_seen >= 100 && byte_stream.size() > 20) begin
            hold_left = 400;
            hold_done = 1'b1;
            nxt_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            nxt_ready = 1'b0;
        end else begin
            rx_stall = pick_gap(cycle_count[9:8] == 2'd1);
            nxt_ready = (rx_stall == 0);
        end
        out_ready <= nxt_ready;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_UPPER_CASE: upper_sites = data[0];
            CFG_VALIDATE:   check_sites = data[0];
            CFG_VSYM_0, CFG_VSYM_1, CFG_VSYM_2, CFG_VSYM_3:
                symbol_set[64 * (idx - CFG_VSYM_0) +: 64] = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic upper, input logic check, input logic [255:0] set);
        write_reg(CFG_UPPER_CASE, {63'd0, upper});
        write_reg(CFG_VALIDATE, {63'd0, check});
        write_reg(CFG_VSYM_0, set[63:0]);
        write_reg(CFG_VSYM_1, set[127:64]);
        write_reg(CFG_VSYM_2, set[191:128]);
        write_reg(CFG_VSYM_3, set[255:192]);
    endtask

    task automatic wait_idle();
        while (byte_stream.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic enqueue_doc(input int doc[$]);
        t_in_req req;
        foreach (doc[i]) begin
            if (doc[i] == EOS_MARK) begin
                req.symbol = 8'($urandom_range(0, 255));
                req.end_of_stream = 1'b1;
            end else begin
                req.symbol = 8'(doc[i]);
                req.end_of_stream = 1'b0;
            end
            byte_stream.insert(byte_stream.size(), req);
        end
        stim_count += doc.size();
    endtask

    // Mostly well-formed documents with random content; some get one defect
    task automatic gen_document();
        int    doc[$];
        int    n;
        int    r;
        int    pos;
        int    ch;
        string alpha;
        alpha = "ACGTNacgtn-*";
        if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(0, 6);
            repeat (n) doc.insert(doc.size(), $urandom_range(0, 255));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                doc.insert(doc.size(), CH_GT);
                repeat ($urandom_range(1, 8))
                    doc.insert(doc.size(), $urandom_range(8'h21, 8'h7E));
                if ($urandom_range(0, 1)) begin
                    doc.insert(doc.size(), CH_SPACE);
                    repeat ($urandom_range(0, 8))
                        doc.insert(doc.size(), $urandom_range(8'h20, 8'h7E));
                end
                doc.insert(doc.size(), CH_NEWLINE);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (n) begin
                    doc.insert(doc.size(), CH_SEMI);
                    repeat ($urandom_range(0, 6)) begin
                        do ch = $urandom_range(0, 255); while (ch == CH_NEWLINE);
                        doc.insert(doc.size(), ch);
                    end
                    doc.insert(doc.size(), CH_NEWLINE);
                end
                repeat ($urandom_range(1, 3)) begin
                    r = $urandom_range(1, 12);
                    repeat (r) begin
                        if ($urandom_range(0, 3) != 0) begin
                            ch = alpha[$urandom_range(0, alpha.len() - 1)];
                        end else begin
                            do ch = $urandom_range(0, 255);
                            while (ch == CH_NEWLINE || ch == CH_GT || ch == CH_SEMI);
                        end
                        doc.insert(doc.size(), ch);
                    end
                    doc.insert(doc.size(), CH_NEWLINE);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                pos = $urandom_range(0, doc.size() - 1);
                case ($urandom_range(0, 4))
                    0: doc[pos] = $urandom_range(0, 255);
                    1: doc.delete(pos);
                    2: while (doc.size() > pos) void'(doc.pop_back());
                    3: doc.insert(pos, CH_NEWLINE);
                    default: doc.insert(pos, CH_GT);
                endcase
            end
        end
        doc.insert(doc.size(), EOS_MARK);
        enqueue_doc(doc);
    endtask

    initial begin
        int           opening[$];
        int unsigned  quota;
        logic [255:0] nucleotide_set;
        logic [255:0] rnd_set;
        string        bases;
        bit           failed;
        opening = '{EOS_MARK,
                    CH_GT, 8'h7E, 8'h21, CH_SPACE, CH_SPACE, 8'h7E, CH_NEWLINE,
                    CH_SEMI, 8'hFF, CH_NEWLINE, 8'h61, 8'h80, CH_NEWLINE,
                    CH_GT, 8'h71, CH_NEWLINE, 8'h7A, CH_NEWLINE, EOS_MARK,
                    CH_GT, 8'h78, 8'h7F, EOS_MARK,
                    CH_GT, 8'h78, EOS_MARK,
                    8'h00, 8'h41, EOS_MARK};
        bases = "ACGTN-*";
        nucleotide_set = '0;
        for (int i = 0; i < bases.len(); i++) nucleotide_set[bases[i]] = 1'b1;
        for (int i = 0; i < 8; i++) rnd_set[32 * i +: 32] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        enqueue_doc(opening);
        for (int step = 0; step < 6; step++) begin
            if (step != 0) begin
                wait_idle();
                case (step)
                    1: set_config(1'b0, 1'b1, '1);
                    2: set_config(1'b1, 1'b1, nucleotide_set);
                    3: set_config(1'b0, 1'b1, rnd_set);
                    4: set_config(1'b1, 1'b0, '0);
                    default: set_config(1'b0, 1'b1, '0);
                endcase
            end
            quota = stim_count + 190;
            while (stim_count < quota) gen_document();
        end
        wait_idle();

        failed = (errors != 0);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
